// ----- hw/rtl/lcg_pkg.sv -----
// ============================================================================
// lcg_pkg: shared types and constants for the linear color gradient block
// Widths of the projection arithmetic, register map codes and the records
// that travel between the pipeline stages.
// ============================================================================
package lcg_pkg;

    localparam int COORD_BITS = 12;
    localparam int CFG_CW     = 13;
    localparam int COLOR_W    = 32;
    localparam int CH_W       = 8;
    localparam int NCH        = COLOR_W / CH_W;

    localparam int REG_CNT = 6;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = $clog2(REG_CNT) + 2;
    localparam int IDX_W   = ADDR_W - 2;

    // Pixel minus start point and end minus start point, both signed.
    localparam int DIFF_W = ((COORD_BITS + 1 > CFG_CW) ? COORD_BITS + 1 : CFG_CW) + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int PSUM_W = PROD_W + 1;
    // Squared segment length, bounded by the configured coordinates alone.
    localparam int LEN_W  = 2 * (CFG_CW + 1) - 1;
    localparam int NUM_W  = LEN_W + CH_W;

    localparam int DIV_STEPS = CH_W;
    localparam int BIT_W     = $clog2(CH_W);

    typedef enum logic [IDX_W-1:0] {
        REG_START_X     = IDX_W'(0),
        REG_START_Y     = IDX_W'(1),
        REG_END_X       = IDX_W'(2),
        REG_END_Y       = IDX_W'(3),
        REG_START_COLOR = IDX_W'(4),
        REG_END_COLOR   = IDX_W'(5)
    } t_reg_idx;

    typedef enum logic [1:0] {
        SEL_START,
        SEL_END,
        SEL_BLEND
    } t_sel;

    typedef struct packed {
        logic signed [CFG_CW-1:0] start_x;
        logic signed [CFG_CW-1:0] start_y;
        logic signed [CFG_CW-1:0] end_x;
        logic signed [CFG_CW-1:0] end_y;
        logic [COLOR_W-1:0]       start_color;
        logic [COLOR_W-1:0]       end_color;
    } t_cfg;

    typedef struct packed {
        logic [COORD_BITS-1:0]    x;
        logic [COORD_BITS-1:0]    y;
        logic signed [DIFF_W-1:0] ex;
        logic signed [DIFF_W-1:0] ey;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
    } t_diff;

    typedef struct packed {
        logic [COORD_BITS-1:0]    x;
        logic [COORD_BITS-1:0]    y;
        logic signed [PROD_W-1:0] pex;
        logic signed [PROD_W-1:0] pey;
        logic [LEN_W-1:0]         ldx;
        logic [LEN_W-1:0]         ldy;
    } t_prod;

    typedef struct packed {
        logic [COORD_BITS-1:0]    x;
        logic [COORD_BITS-1:0]    y;
        logic signed [PSUM_W-1:0] p;
        logic [LEN_W-1:0]         len;
    } t_sum;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        t_sel                  sel;
        logic [LEN_W-1:0]      len;
        logic [LEN_W-1:0]      pu;
        logic [LEN_W-1:0]      lmp;
    } t_proj;

    typedef struct packed {
        logic [COORD_BITS-1:0]          x;
        logic [COORD_BITS-1:0]          y;
        t_sel                           sel;
        logic [LEN_W-1:0]               len;
        logic [NCH-1:0][NUM_W-1:0]      pa;
        logic [NCH-1:0][NUM_W-1:0]      pb;
    } t_mix;

    typedef struct packed {
        logic [COORD_BITS-1:0]          x;
        logic [COORD_BITS-1:0]          y;
        t_sel                           sel;
        logic [LEN_W-1:0]               len;
        logic [NCH-1:0][NUM_W-1:0]      rem;
        logic [NCH-1:0][CH_W-1:0]       q;
    } t_div;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COLOR_W-1:0]    color;
    } t_res;

endpackage

// ----- hw/rtl/lcg_if.sv -----
// ============================================================================
// lcg_if: pixel and result channels of the linear color gradient block
// Valid/ready channels; a word moves at a clock edge with valid and ready high.
// ============================================================================
interface lcg_pix_if;
    import lcg_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface lcg_res_if;
    import lcg_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] out_x;
    logic [COORD_BITS-1:0] out_y;
    logic [COLOR_W-1:0]    pixel_color;

    modport source (output valid, output out_x, output out_y, output pixel_color,
                    input ready);
    modport sink   (input valid, input out_x, input out_y, input pixel_color,
                    output ready);
endinterface

// ----- hw/rtl/lcg_apb_regs.sv -----
// ============================================================================
// lcg_apb_regs: configuration register file
// Holds the two gradient points and their colors, written and read over APB.
// ============================================================================
module lcg_apb_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [lcg_pkg::ADDR_W-1:0]    i_paddr,
    input  logic [lcg_pkg::DATA_W-1:0]    i_pwdata,
    output logic [lcg_pkg::DATA_W-1:0]    o_prdata,
    output lcg_pkg::t_cfg                 o_cfg
);
    import lcg_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx = t_reg_idx'(i_paddr[ADDR_W-1:2]);
    assign w_wr  = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_START_X:     r_cfg.start_x     <= i_pwdata[CFG_CW-1:0];
                REG_START_Y:     r_cfg.start_y     <= i_pwdata[CFG_CW-1:0];
                REG_END_X:       r_cfg.end_x       <= i_pwdata[CFG_CW-1:0];
                REG_END_Y:       r_cfg.end_y       <= i_pwdata[CFG_CW-1:0];
                REG_START_COLOR: r_cfg.start_color <= i_pwdata[COLOR_W-1:0];
                REG_END_COLOR:   r_cfg.end_color   <= i_pwdata[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_START_X:     o_prdata = {{(DATA_W-CFG_CW){1'b0}}, r_cfg.start_x};
            REG_START_Y:     o_prdata = {{(DATA_W-CFG_CW){1'b0}}, r_cfg.start_y};
            REG_END_X:       o_prdata = {{(DATA_W-CFG_CW){1'b0}}, r_cfg.end_x};
            REG_END_Y:       o_prdata = {{(DATA_W-CFG_CW){1'b0}}, r_cfg.end_y};
            REG_START_COLOR: o_prdata = DATA_W'(r_cfg.start_color);
            REG_END_COLOR:   o_prdata = DATA_W'(r_cfg.end_color);
            default:         o_prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hw/rtl/lcg_geom.sv -----
// ============================================================================
// lcg_geom: projection of the pixel onto the gradient axis
// Four stages: differences, products, dot-product sums, clamp classification.
// ============================================================================
module lcg_geom (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_vld,
    input  logic [lcg_pkg::COORD_BITS-1:0]    i_x,
    input  logic [lcg_pkg::COORD_BITS-1:0]    i_y,
    input  lcg_pkg::t_cfg                     i_cfg,
    output logic                              o_vld,
    output lcg_pkg::t_proj                    o_proj
);
    import lcg_pkg::*;

    logic  r_vld1, r_vld2, r_vld3, r_vld4;
    t_diff r_s1, n_s1;
    t_prod r_s2, n_s2;
    t_sum  r_s3, n_s3;
    t_proj r_s4, n_s4;

    logic                     w_zero;
    logic signed [PROD_W-1:0] w_sqx, w_sqy;
    logic                     w_neg, w_over;

    // Stage 1: offsets from the start point.
    always_comb begin
        n_s1.x  = i_x;
        n_s1.y  = i_y;
        n_s1.ex = $signed({{(DIFF_W-COORD_BITS){1'b0}}, i_x})
                  - DIFF_W'($signed(i_cfg.start_x));
        n_s1.ey = $signed({{(DIFF_W-COORD_BITS){1'b0}}, i_y})
                  - DIFF_W'($signed(i_cfg.start_y));
        n_s1.dx = DIFF_W'($signed(i_cfg.end_x)) - DIFF_W'($signed(i_cfg.start_x));
        n_s1.dy = DIFF_W'($signed(i_cfg.end_y)) - DIFF_W'($signed(i_cfg.start_y));
    end

    // Stage 2: one multiplier per product term.
    assign w_sqx  = PROD_W'(r_s1.dx) * PROD_W'(r_s1.dx);
    assign w_sqy  = PROD_W'(r_s1.dy) * PROD_W'(r_s1.dy);
    assign w_zero = (r_s1.dx == '0) && (r_s1.dy == '0);

    always_comb begin
        n_s2.x   = r_s1.x;
        n_s2.y   = r_s1.y;
        n_s2.pex = PROD_W'(r_s1.ex) * PROD_W'(r_s1.dx);
        n_s2.pey = PROD_W'(r_s1.ey) * PROD_W'(r_s1.dy);
        n_s2.ldx = w_sqx[LEN_W-1:0];
        n_s2.ldy = w_sqy[LEN_W-1:0];
    end

    // Stage 3: dot product and squared length.
    always_comb begin
        n_s3.x   = r_s2.x;
        n_s3.y   = r_s2.y;
        n_s3.p   = PSUM_W'(r_s2.pex) + PSUM_W'(r_s2.pey);
        n_s3.len = r_s2.ldx + r_s2.ldy;
    end

    // Stage 4: clamp decision and the two interpolation weights.
    assign w_neg  = r_s3.p[PSUM_W-1];
    assign w_over = !w_neg && (r_s3.p[PSUM_W-2:0] > (PSUM_W-1)'(r_s3.len));

    always_comb begin
        n_s4.x   = r_s3.x;
        n_s4.y   = r_s3.y;
        n_s4.len = r_s3.len;
        n_s4.pu  = r_s3.p[LEN_W-1:0];
        n_s4.lmp = r_s3.len - r_s3.p[LEN_W-1:0];
        if (w_neg) begin
            n_s4.sel = SEL_START;
        end else if (w_over) begin
            n_s4.sel = SEL_END;
        end else begin
            n_s4.sel = SEL_BLEND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            // Coincident points have no axis; the word is dropped here.
            r_vld2 <= r_vld1 && !w_zero;
            r_vld3 <= r_vld2;
            r_vld4 <= r_vld3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
            r_s4 <= n_s4;
        end
    end

    assign o_vld  = r_vld4;
    assign o_proj = r_s4;

endmodule

// ----- hw/rtl/lcg_blend.sv -----
// ============================================================================
// lcg_blend: weighted channel sums
// Two stages: per-channel products with both weights, then their sums.
// ============================================================================
module lcg_blend (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  lcg_pkg::t_proj  i_proj,
    input  lcg_pkg::t_cfg   i_cfg,
    output logic            o_vld,
    output lcg_pkg::t_div   o_div
);
    import lcg_pkg::*;

    logic r_vld5, r_vld6;
    t_mix r_s5, n_s5;
    t_div r_s6, n_s6;

    always_comb begin
        n_s5.x   = i_proj.x;
        n_s5.y   = i_proj.y;
        n_s5.sel = i_proj.sel;
        n_s5.len = i_proj.len;
        for (int c = 0; c < NCH; c++) begin
            n_s5.pa[c] = NUM_W'(i_cfg.start_color[c*CH_W +: CH_W]) * NUM_W'(i_proj.lmp);
            n_s5.pb[c] = NUM_W'(i_cfg.end_color[c*CH_W +: CH_W]) * NUM_W'(i_proj.pu);
        end
    end

    // For a blend the sum stays below 256 times the length and cannot overflow.
    always_comb begin
        n_s6.x   = r_s5.x;
        n_s6.y   = r_s5.y;
        n_s6.sel = r_s5.sel;
        n_s6.len = r_s5.len;
        n_s6.q   = '0;
        for (int c = 0; c < NCH; c++) begin
            n_s6.rem[c] = r_s5.pa[c] + r_s5.pb[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld5 <= 1'b0;
            r_vld6 <= 1'b0;
        end else if (i_en) begin
            r_vld5 <= i_vld;
            r_vld6 <= r_vld5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s5 <= n_s5;
            r_s6 <= n_s6;
        end
    end

    assign o_vld = r_vld6;
    assign o_div = r_s6;

endmodule

// ----- hw/rtl/lcg_div_stage.sv -----
// ============================================================================
// lcg_div_stage: one restoring division step for all four channels
// Resolves one quotient bit of each channel sum divided by the length.
// ============================================================================
module lcg_div_stage (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_vld,
    input  logic [lcg_pkg::BIT_W-1:0]    i_bit,
    input  lcg_pkg::t_div                i_div,
    output logic                         o_vld,
    output lcg_pkg::t_div                o_div
);
    import lcg_pkg::*;

    logic             r_vld;
    t_div             r_div, n_div;
    logic [NUM_W-1:0] w_dvs;
    logic [NUM_W:0]   w_trial [NCH];

    // The shifted length fits because the length is far narrower than the sum.
    assign w_dvs = NUM_W'(i_div.len) << i_bit;

    always_comb begin
        n_div = i_div;
        for (int c = 0; c < NCH; c++) begin
            w_trial[c] = {1'b0, i_div.rem[c]} - {1'b0, w_dvs};
            if (!w_trial[c][NUM_W]) begin
                n_div.rem[c]       = w_trial[c][NUM_W-1:0];
                n_div.q[c][i_bit]  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_vld = r_vld;
    assign o_div = r_div;

endmodule

// ----- hw/rtl/linear_color_gradient.sv -----
// ============================================================================
// linear_color_gradient: ARGB color of a pixel on a linear gradient
// Projects each pixel onto the segment between two configured points and
// returns the clamped, exactly interpolated 32-bit color.
// ============================================================================
// The block takes one pixel word per clock and returns one colored pixel word
// per clock while the output is taken. Inside, four stages compute the
// projection p of the pixel onto the segment and its squared length L, two
// stages form the weighted channel sums c1*(L-p) + c2*p, eight stages each
// resolve one quotient bit of the four channel divisions by L, and one output
// register holds the result. The throughput is one word per clock while the
// output is taken, because every division step has its own subtractor.
// Pixels before the start point get the start color and pixels past the end
// point get the end color. When both points coincide, no word comes out for
// that pixel. A stalled output fills the output register and then a one-word
// skid register before the input drops ready, so the two sides are decoupled
// by a register. Configuration is written over APB with no wait states, at
// byte address 4*i for register i (start x, start y, end x, end y, start color,
// end color); it must only change while no pixel is in flight.
module linear_color_gradient (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    lcg_pix_if.sink                       i_pix,
    lcg_res_if.source                     o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lcg_pkg::ADDR_W-1:0]    paddr,
    input  logic [lcg_pkg::DATA_W-1:0]    pwdata,
    output logic [lcg_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import lcg_pkg::*;

    t_cfg  w_cfg;
    logic  w_en;
    logic  w_gvld;
    t_proj w_proj;

    // Division chain taps: index 0 is the blend output, the last is the result.
    logic  w_dvld [DIV_STEPS+1];
    t_div  w_div  [DIV_STEPS+1];

    t_res  w_res;
    logic  w_push, w_pop;

    logic  r_out_vld, n_out_vld;
    t_res  r_out, n_out;
    logic  r_skid_vld, n_skid_vld;
    t_res  r_skid, n_skid;

    assign pready = 1'b1;

    lcg_apb_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (w_cfg)
    );

    // The whole pipeline moves together; it only halts when the skid register
    // is occupied, which means both output registers hold undelivered words.
    assign w_en        = !r_skid_vld;
    assign i_pix.ready = w_en;

    lcg_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_pix.valid),
        .i_x     (i_pix.pixel_x),
        .i_y     (i_pix.pixel_y),
        .i_cfg   (w_cfg),
        .o_vld   (w_gvld),
        .o_proj  (w_proj)
    );

    lcg_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_gvld),
        .i_proj  (w_proj),
        .i_cfg   (w_cfg),
        .o_vld   (w_dvld[0]),
        .o_div   (w_div[0])
    );

    // Quotient bits are resolved from the most significant one down.
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        lcg_div_stage u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_dvld[k]),
            .i_bit   (BIT_W'(DIV_STEPS - 1 - k)),
            .i_div   (w_div[k]),
            .o_vld   (w_dvld[k+1]),
            .o_div   (w_div[k+1])
        );
    end

    // Clamped pixels take a configured color as is. The user must not change the
    // configuration while a word is in flight; the block does not enforce it.
    always_comb begin
        w_res.x = w_div[DIV_STEPS].x;
        w_res.y = w_div[DIV_STEPS].y;
        case (w_div[DIV_STEPS].sel)
            SEL_START: w_res.color = w_cfg.start_color;
            SEL_END:   w_res.color = w_cfg.end_color;
            SEL_BLEND: w_res.color = w_div[DIV_STEPS].q;
            default:   w_res.color = w_div[DIV_STEPS].q;
        endcase
    end

    assign w_push = w_en && w_dvld[DIV_STEPS];
    assign w_pop  = r_out_vld && o_res.ready;

    // Output register with a skid register behind it. A word leaving the
    // pipeline goes to the output register when that is free or being drained,
    // and otherwise parks in the skid register.
    always_comb begin
        n_out_vld  = r_out_vld;
        n_out      = r_out;
        n_skid_vld = r_skid_vld;
        n_skid     = r_skid;
        if (r_skid_vld) begin
            if (w_pop) begin
                n_out      = r_skid;
                n_skid_vld = 1'b0;
            end
        end else if (w_push) begin
            if (!r_out_vld || w_pop) begin
                n_out     = w_res;
                n_out_vld = 1'b1;
            end else begin
                n_skid     = w_res;
                n_skid_vld = 1'b1;
            end
        end else if (w_pop) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_res.valid       = r_out_vld;
    assign o_res.out_x       = r_out.x;
    assign o_res.out_y       = r_out.y;
    assign o_res.pixel_color = r_out.color;

`ifndef SYNTH
    // The skid register is only ever filled behind an occupied output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid register holds a word while the output register is empty");

    // Input ready only drops after the output was offered and refused.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> $past(o_res.valid && !o_res.ready))
        else $error("input stalled without a refused output word");

    // A new output word must have come out of the last division step.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(w_push))
        else $error("output word appeared without leaving the pipeline");
`endif

endmodule

// ----- tb/sv/linear_color_gradient_test.sv -----
// ============================================================================
// linear_color_gradient_test: self-checking bench for the gradient colorer
// Loads gradients over APB, streams pixel words with random gaps on both
// channels and checks every colored word against an integer projection
// predictor kept in step with the configuration writes.
// ============================================================================
module linear_color_gradient_test;
    import lcg_pkg::*;

    // Longest stretch without any accepted word, pixel, result or register
    // write, before the run is declared hung. The longest legal quiet stretch
    // is the deliberate output hold-off in the stall test plus pipeline depth.
    localparam int QUIET_LIMIT  = 3000;
    // Cycles allowed after the last expected word before touching registers:
    // fourteen pipeline stages plus the output and skid registers, with margin.
    localparam int DRAIN_CYCLES = 32;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_REPORTS  = 10;

    // Two indexes past the register map; writes there must change nothing.
    localparam logic [IDX_W-1:0] REG_UNMAPPED_LO = IDX_W'(6);
    localparam logic [IDX_W-1:0] REG_UNMAPPED_HI = IDX_W'(7);

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    lcg_pix_if pix_bus ();
    lcg_res_if res_bus ();

    linear_color_gradient i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_bus),
        .o_res   (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Shadow of the gradient registers, as the block should hold them.
    logic signed [CFG_CW-1:0] org_x;
    logic signed [CFG_CW-1:0] org_y;
    logic signed [CFG_CW-1:0] dst_x;
    logic signed [CFG_CW-1:0] dst_y;
    logic [COLOR_W-1:0]       org_color;
    logic [COLOR_W-1:0]       dst_color;

    // Colored pixels still owed by the block, oldest first.
    t_res colors_due[$];

    int fault_cnt;
    int pix_gap_max;
    int res_stall_max;
    int res_hold_cycles;

    // Projects a pixel onto the start-to-end segment and blends the two
    // colors exactly. Returns 0 when the points coincide, since the block
    // then emits no word for the pixel.
    function automatic bit shade_pixel(input logic [COORD_BITS-1:0] px,
                                       input logic [COORD_BITS-1:0] py,
                                       output logic [COLOR_W-1:0] color);
        longint sx;
        longint sy;
        longint dx;
        longint dy;
        longint seg_len;
        longint proj;
        longint num;
        int     sh;
        color = '0;
        sx = longint'(org_x);
        sy = longint'(org_y);
        dx = longint'(dst_x) - sx;
        dy = longint'(dst_y) - sy;
        if (dx == 0 && dy == 0) begin
            return 1'b0;
        end
        seg_len = dx * dx + dy * dy;
        proj    = (longint'(px) - sx) * dx + (longint'(py) - sy) * dy;
        if (proj < 0) begin
            color = org_color;
        end else if (proj > seg_len) begin
            color = dst_color;
        end else begin
            // Both weights are non-negative here, so the division floors.
            for (sh = 0; sh < COLOR_W; sh += CH_W) begin
                num = longint'(org_color[sh +: CH_W]) * (seg_len - proj)
                    + longint'(dst_color[sh +: CH_W]) * proj;
                color[sh +: CH_W] = CH_W'(num / seg_len);
            end
        end
        return 1'b1;
    endfunction

    // One APB write: setup, then access until pready. psel and penable are
    // left high so that a following write in the same time step only has to
    // drop penable; a batch of writes always ends with apb_release.
    task automatic apb_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        // Only the low bits of each register are kept; unmapped indexes are
        // dropped.
        case (idx)
            REG_START_X:     org_x = value[CFG_CW-1:0];
            REG_START_Y:     org_y = value[CFG_CW-1:0];
            REG_END_X:       dst_x = value[CFG_CW-1:0];
            REG_END_Y:       dst_y = value[CFG_CW-1:0];
            REG_START_COLOR: org_color = value[COLOR_W-1:0];
            REG_END_COLOR:   dst_color = value[COLOR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apb_release();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Writes all six registers. Coordinates carry random junk above bit 12
    // to check that the block keeps only the register's low bits.
    task automatic load_gradient(input logic [CFG_CW-1:0] sx, input logic [CFG_CW-1:0] sy,
                                 input logic [CFG_CW-1:0] ex, input logic [CFG_CW-1:0] ey,
                                 input logic [COLOR_W-1:0] c1, input logic [COLOR_W-1:0] c2);
        apb_write(REG_START_X, {(DATA_W - CFG_CW)'($urandom), sx});
        apb_write(REG_START_Y, {(DATA_W - CFG_CW)'($urandom), sy});
        apb_write(REG_END_X, {(DATA_W - CFG_CW)'($urandom), ex});
        apb_write(REG_END_Y, {(DATA_W - CFG_CW)'($urandom), ey});
        apb_write(REG_START_COLOR, c1);
        apb_write(REG_END_COLOR, c2);
    endtask

    // Offers one pixel word after a random gap and records the colored word
    // the block owes for it. A zero gap keeps valid high straight through.
    task automatic send_pixel(input logic [COORD_BITS-1:0] px, input logic [COORD_BITS-1:0] py);
        int                 gap;
        logic [COLOR_W-1:0] color;
        gap = $urandom_range(0, pix_gap_max);
        if (gap > 0) begin
            pix_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_bus.valid   <= 1'b1;
        pix_bus.pixel_x <= px;
        pix_bus.pixel_y <= py;
        do @(posedge i_clk); while (pix_bus.ready !== 1'b1);
        if (shade_pixel(px, py, color)) begin
            colors_due.push_back('{x: px, y: py, color: color});
        end
    endtask

    task automatic stop_pixels();
        pix_bus.valid <= 1'b0;
    endtask

    // Registers may only change once the pipeline is empty. Pixels with no
    // result can still be inside after the last word, hence the extra wait.
    task automatic settle();
        while (colors_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // After reset both points sit at the origin, and later a nonzero pair of
    // equal points: neither may produce a word.
    task automatic check_coincident_points();
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd1234, 12'd567);
        stop_pixels();
        settle();
        load_gradient(-13'sd4096, 13'sd4095, -13'sd4096, 13'sd4095,
                      32'h1234_5678, 32'h9ABC_DEF0);
        apb_release();
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        stop_pixels();
        settle();
    endtask

    // Horizontal segment: one pixel before the start, both end points
    // exactly, one inside and one past the end.
    task automatic check_horizontal_gradient();
        load_gradient(13'sd16, 13'sd0, 13'sd271, 13'sd0, 32'h00FF_8001, 32'hFF00_7FFE);
        apb_release();
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd16, 12'd0);
        send_pixel(12'd271, 12'd2000);
        send_pixel(12'd144, 12'd17);
        send_pixel(12'd4095, 12'd4095);
        stop_pixels();
        settle();
    endtask

    // Vertical segment running upward, so the end point has the smaller row.
    task automatic check_reversed_vertical_gradient();
        load_gradient(13'sd5, 13'sd4000, 13'sd5, 13'sd100, 32'h80C0_4020, 32'h0F1E_2D3C);
        apb_release();
        send_pixel(12'd5, 12'd4000);
        send_pixel(12'd5, 12'd100);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd17, 12'd2048);
        stop_pixels();
        settle();
    endtask

    // Diagonal across the whole coordinate range, from the largest corner to
    // the smallest, with extreme colors. The unmapped writes come last so a
    // decoder that aliases them onto real registers would bend the gradient.
    task automatic check_sloped_extremes();
        load_gradient(13'sd4095, 13'sd4095, -13'sd4096, -13'sd4096,
                      32'hFFFF_FFFF, 32'h0000_0000);
        apb_write(REG_UNMAPPED_LO, $urandom);
        apb_write(REG_UNMAPPED_HI, $urandom);
        apb_release();
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd2048, 12'd1000);
        stop_pixels();
        settle();
    endtask

    // The receiver holds off for a long stretch while pixels keep coming at
    // full rate, so the pipeline fills and must drop ready without losing or
    // repeating a word.
    task automatic check_output_stall();
        int n;
        load_gradient(13'sd100, 13'sd3900, 13'sd3800, 13'sd300, $urandom, $urandom);
        apb_release();
        pix_gap_max     = 0;
        res_stall_max   = 0;
        res_hold_cycles = HOLD_CYCLES;
        for (n = 0; n < 60; n++) begin
            send_pixel(12'($urandom), 12'($urandom));
        end
        stop_pixels();
        settle();
    endtask

    // Segments of random pixels, each under a fresh random gradient and its
    // own idling mix. Kinds rotate through general, horizontal, vertical and
    // very short segments; for short ones half the pixels land near the
    // segment so the blend region is still reached.
    task automatic check_random_gradients();
        int seg_gap[8]   = '{0, 12, 0, 12, 3, 0, 12, 6};
        int seg_stall[8] = '{0, 0, 12, 12, 5, 0, 12, 2};
        int seg;
        int n;
        int kind;
        int sx;
        int sy;
        int ex;
        int ey;
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
        for (seg = 0; seg < 8; seg++) begin
            kind = seg % 4;
            sx = int'($urandom_range(0, 8191)) - 4096;
            sy = int'($urandom_range(0, 8191)) - 4096;
            ex = int'($urandom_range(0, 8191)) - 4096;
            ey = int'($urandom_range(0, 8191)) - 4096;
            case (kind)
                1: ey = sy;
                2: ex = sx;
                3: begin
                    sx = $urandom_range(16, 4079);
                    sy = $urandom_range(16, 4079);
                    ex = sx + int'($urandom_range(0, 32)) - 16;
                    ey = sy + int'($urandom_range(0, 32)) - 16;
                    if (ex == sx && ey == sy) begin
                        ex = sx + 1;
                    end
                end
                default: ;
            endcase
            load_gradient(CFG_CW'(sx), CFG_CW'(sy), CFG_CW'(ex), CFG_CW'(ey),
                          $urandom, $urandom);
            apb_release();
            pix_gap_max   = seg_gap[seg];
            res_stall_max = seg_stall[seg];
            for (n = 0; n < 100; n++) begin
                px = 12'($urandom);
                py = 12'($urandom);
                if (kind == 3 && $urandom_range(0, 1) == 1) begin
                    px = 12'(sx + int'($urandom_range(0, 48)) - 24);
                    py = 12'(sy + int'($urandom_range(0, 48)) - 24);
                end
                send_pixel(px, py);
            end
            stop_pixels();
            settle();
        end
    endtask

    // Result receiver: a random stall before each word, or one long hold-off
    // when the stall test asks for it.
    initial begin : res_receiver
        int stall;
        res_bus.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (res_hold_cycles > 0) begin
                stall           = res_hold_cycles;
                res_hold_cycles = 0;
            end else begin
                stall = $urandom_range(0, res_stall_max);
            end
            if (stall > 0) begin
                res_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_bus.ready <= 1'b1;
            do @(posedge i_clk); while (res_bus.valid !== 1'b1);
        end
    end

    // Every accepted word is matched against the oldest owed pixel.
    always @(posedge i_clk) begin : color_checker
        t_res due;
        if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
            if (colors_due.size() == 0) begin
                if (fault_cnt < MAX_REPORTS) begin
                    $display("unexpected word: pixel (%0d,%0d) color %h",
                             res_bus.out_x, res_bus.out_y, res_bus.pixel_color);
                end
                fault_cnt++;
            end else begin
                due = colors_due.pop_front();
                if (res_bus.out_x !== due.x || res_bus.out_y !== due.y
                        || res_bus.pixel_color !== due.color) begin
                    if (fault_cnt < MAX_REPORTS) begin
                        $display("word mismatch: got (%0d,%0d) color %h, want (%0d,%0d) color %h",
                                 res_bus.out_x, res_bus.out_y, res_bus.pixel_color,
                                 due.x, due.y, due.color);
                    end
                    fault_cnt++;
                end
            end
        end
    end

    // Hang detector: counts cycles in which no word moves on any port.
    always @(posedge i_clk) begin : watchdog
        int quiet;
        if ((pix_bus.valid === 1'b1 && pix_bus.ready === 1'b1)
                || (res_bus.valid === 1'b1 && res_bus.ready === 1'b1)
                || (psel === 1'b1 && penable === 1'b1 && pready === 1'b1)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("[linear_color_gradient] ERROR");
                $finish;
            end
        end
    end

    initial begin
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        pix_bus.valid   <= 1'b0;
        pix_bus.pixel_x <= '0;
        pix_bus.pixel_y <= '0;
        i_rst_n         <= 1'b0;
        org_x           = '0;
        org_y           = '0;
        dst_x           = '0;
        dst_y           = '0;
        org_color       = '0;
        dst_color       = '0;
        fault_cnt       = 0;
        pix_gap_max     = 4;
        res_stall_max   = 4;
        res_hold_cycles = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        check_coincident_points();
        check_horizontal_gradient();
        check_reversed_vertical_gradient();
        check_sloped_extremes();
        check_output_stall();
        check_random_gradients();

        if (fault_cnt == 0) begin
            $display("[linear_color_gradient] OK");
        end else begin
            $display("[linear_color_gradient] ERROR");
        end
        $finish;
    end

endmodule
